// ===== design/brs_pkg.sv =====
package brs_pkg;

    // Operation carried by an input item.
    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_READ = 1'b1
    } op_t;

    // Configuration register indexes.
    typedef enum logic [1:0]
    {
        REG_SRC_WIDTH   = 2'd0,
        REG_SRC_HEIGHT  = 2'd1,
        REG_TARGET_SIZE = 2'd2,
        REG_NIGHT_MODE  = 2'd3
    } reg_idx_t;

    // Register file contents.
    typedef struct packed
    {
        logic [6:0] src_width;
        logic [6:0] src_height;
        logic [7:0] target_size;
        logic       night_mode;
    } cfg_t;

    // Classified item passed from the front end to the back end.
    typedef struct packed
    {
        op_t         op;
        logic        wr;
        logic [7:0]  col;
        logic [7:0]  row;
        logic [7:0]  last;
        logic [23:0] pix;
    } item_t;

    localparam logic [6:0] SRC_WIDTH_RESET   = 7'd32;
    localparam logic [6:0] SRC_HEIGHT_RESET  = 7'd32;
    localparam logic [7:0] TARGET_SIZE_RESET = 8'd32;

    // Night tint coefficients in Q0.8.
    localparam logic [6:0] NIGHT_RED_Q8      = 7'd77;
    localparam logic [6:0] NIGHT_GREEN_Q8    = 7'd90;
    localparam logic [7:0] NIGHT_BLUE_OFFSET = 8'd64;

endpackage

// ===== design/brs_if.sv =====
interface brs_pix_if;
    import brs_pkg::*;
    logic       valid;
    logic       ready;
    op_t        operation;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;

    modport source(output valid, operation, col, row, in_red, in_green, in_blue, input ready);
    modport sink(input valid, operation, col, row, in_red, in_green, in_blue, output ready);
endinterface

interface brs_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_col;
    logic [7:0] out_row;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;

    modport source(output valid, out_col, out_row, out_red, out_green, out_blue, input ready);
    modport sink(input valid, out_col, out_row, out_red, out_green, out_blue, output ready);
endinterface

interface brs_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== design/brs_front.sv =====
module brs_front #(
    parameter int MAX_SIDE = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    brs_cfg_if.sink        cfg,
    brs_pix_if.sink        pix_in,
    output brs_pkg::cfg_t  cfg_q,
    output brs_pkg::item_t item,
    output logic           item_valid,
    input  logic           item_ready
);
    import brs_pkg::*;

    localparam int SW = $clog2(MAX_SIDE + 1);

    cfg_t          cfg_reg;
    logic [SW-1:0] w_eff;
    logic [SW-1:0] h_eff;
    logic [7:0]    last;

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_width   <= SRC_WIDTH_RESET;
            cfg_reg.src_height  <= SRC_HEIGHT_RESET;
            cfg_reg.target_size <= TARGET_SIZE_RESET;
            cfg_reg.night_mode  <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (reg_idx_t'(cfg.index))
                REG_SRC_WIDTH:   cfg_reg.src_width   <= cfg.data[6:0];
                REG_SRC_HEIGHT:  cfg_reg.src_height  <= cfg.data[6:0];
                REG_TARGET_SIZE: cfg_reg.target_size <= cfg.data;
                REG_NIGHT_MODE:  cfg_reg.night_mode  <= cfg.data[0];
                default:         cfg_reg.night_mode  <= cfg_reg.night_mode;
            endcase
        end
    end

    assign cfg_q = cfg_reg;

    // Effective source sizes, limited to the store dimensions.
    always_comb
    begin
        if (cfg_reg.src_width == 7'd0)
            w_eff = SW'(1);
        else if (32'(cfg_reg.src_width) > MAX_SIDE)
            w_eff = SW'(MAX_SIDE);
        else
            w_eff = SW'(cfg_reg.src_width);
        if (cfg_reg.src_height == 7'd0)
            h_eff = SW'(1);
        else if (32'(cfg_reg.src_height) > MAX_SIDE)
            h_eff = SW'(MAX_SIDE);
        else
            h_eff = SW'(cfg_reg.src_height);
    end

    // Last target coordinate; a zero size acts as one.
    assign last = (cfg_reg.target_size == 8'd0) ? 8'd0 : cfg_reg.target_size - 8'd1;

    // Classify the item: clamp read coordinates, range check loads.
    always_comb
    begin
        item.op   = pix_in.operation;
        item.last = last;
        item.pix  = {pix_in.in_red, pix_in.in_green, pix_in.in_blue};
        item.wr   = (pix_in.operation == OP_LOAD) &&
                    (32'(pix_in.col) < 32'(w_eff)) && (32'(pix_in.row) < 32'(h_eff));
        if (pix_in.operation == OP_READ)
        begin
            item.col = (pix_in.col > last) ? last : pix_in.col;
            item.row = (pix_in.row > last) ? last : pix_in.row;
        end
        else
        begin
            item.col = pix_in.col;
            item.row = pix_in.row;
        end
    end

    assign item_valid   = pix_in.valid;
    assign pix_in.ready = item_ready;

endmodule

// ===== design/brs_queue.sv =====
module brs_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  brs_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output brs_pkg::item_t out_item
);
    import brs_pkg::*;

    item_t      slot_reg [2];
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       wp_reg;
    logic       rp_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = slot_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            wp_reg    <= 1'b0;
            rp_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wp_reg] <= in_item;
    end

endmodule

// ===== design/brs_back.sv =====
module brs_back #(
    parameter int MAX_SIDE = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  brs_pkg::cfg_t  cfg_q,
    input  logic           item_valid,
    output logic           item_ready,
    input  brs_pkg::item_t item,
    brs_res_if.source      pix_out
);
    import brs_pkg::*;

    localparam int CW   = $clog2(MAX_SIDE);
    localparam int QW   = CW + 8;
    localparam int DW   = QW + 8;
    localparam int SW   = $clog2(MAX_SIDE + 1);
    localparam int HALF = (MAX_SIDE + 1) / 2;
    localparam int BD   = HALF * HALF;
    localparam int BA   = (BD > 1) ? $clog2(BD) : 1;

    typedef struct packed
    {
        item_t         it;
        logic [7:0]    rx;
        logic [7:0]    ry;
        logic [QW-1:0] qx;
        logic [QW-1:0] qy;
        logic [DW-1:0] nx;
        logic [DW-1:0] ny;
    } div_t;

    typedef struct packed
    {
        op_t           op;
        logic          wr;
        logic [7:0]    col;
        logic [7:0]    row;
        logic [23:0]   pix;
        logic [CW-1:0] ix;
        logic [CW-1:0] iy;
        logic [7:0]    fx;
        logic [7:0]    fy;
        logic          has_r;
        logic          has_d;
    } addr_t;

    typedef struct packed
    {
        logic [7:0] col;
        logic [7:0] row;
        logic [7:0] fx;
        logic [7:0] fy;
        logic       has_r;
        logic       has_d;
        logic       ix0;
        logic       iy0;
    } fetch_t;

    typedef struct packed
    {
        logic [7:0]  col;
        logic [7:0]  row;
        logic [23:0] pa;
        logic [23:0] pb;
        logic [23:0] pc;
        logic [23:0] pd;
        logic [16:0] wa;
        logic [16:0] wb;
        logic [16:0] wc;
        logic [16:0] wd;
    } weight_t;

    typedef struct packed
    {
        logic [7:0]       col;
        logic [7:0]       row;
        logic [2:0][24:0] pr_a;
        logic [2:0][24:0] pr_b;
        logic [2:0][24:0] pr_c;
        logic [2:0][24:0] pr_d;
    } prod_t;

    typedef struct packed
    {
        logic [7:0]  col;
        logic [7:0]  row;
        logic [23:0] ch;
    } blend_t;

    function automatic logic [8:0] div_step(input logic [7:0] rem, input logic nbit,
                                            input logic [7:0] d);
        logic [8:0] t;
        logic       ge;
        t  = {rem, nbit};
        ge = (t >= {1'b0, d});
        div_step = ge ? {1'b1, 8'(t - {1'b0, d})} : {1'b0, t[7:0]};
    endfunction

    function automatic logic [BA-1:0] bank_addr(input logic [CW-1:0] c, input logic [CW-1:0] r);
        bank_addr = BA'((32'(r) >> 1) * HALF + (32'(c) >> 1));
    endfunction

    logic [SW-1:0] w_eff;
    logic [SW-1:0] h_eff;
    logic [CW-1:0] wm1;
    logic [CW-1:0] hm1;

    // Effective source sizes.
    always_comb
    begin
        if (cfg_q.src_width == 7'd0)
            w_eff = SW'(1);
        else if (32'(cfg_q.src_width) > MAX_SIDE)
            w_eff = SW'(MAX_SIDE);
        else
            w_eff = SW'(cfg_q.src_width);
        if (cfg_q.src_height == 7'd0)
            h_eff = SW'(1);
        else if (32'(cfg_q.src_height) > MAX_SIDE)
            h_eff = SW'(MAX_SIDE);
        else
            h_eff = SW'(cfg_q.src_height);
    end

    assign wm1 = CW'(w_eff - SW'(1));
    assign hm1 = CW'(h_eff - SW'(1));

    // Pipeline valids and per-stage ready.
    logic          dv_reg [QW];
    logic          rdy_div [QW];
    div_t          div_reg [QW];
    div_t          div_in [QW];
    div_t          div_next [QW];
    logic          div_in_v [QW];
    logic          a_v_reg;
    logic          b_v_reg;
    logic          c_v_reg;
    logic          d_v_reg;
    logic          e_v_reg;
    logic          o_v_reg;
    logic          rdy_a;
    logic          rdy_b;
    logic          rdy_c;
    logic          rdy_d;
    logic          rdy_e;
    logic          rdy_o;

    assign rdy_o = !o_v_reg || pix_out.ready;
    assign rdy_e = !e_v_reg || rdy_o;
    assign rdy_d = !d_v_reg || rdy_e;
    assign rdy_c = !c_v_reg || rdy_d;
    assign rdy_b = !b_v_reg || rdy_c;
    assign rdy_a = !a_v_reg || rdy_b;

    always_comb
    begin
        rdy_div[QW-1] = !dv_reg[QW-1] || rdy_a;
        for (int k = QW - 2; k >= 0; k--)
            rdy_div[k] = !dv_reg[k] || rdy_div[k+1];
    end

    assign item_ready = rdy_div[0];

    // Divider input: scaled coordinates t*(S-1)*256 and the initial remainder.
    logic [CW+7:0] prod_x;
    logic [CW+7:0] prod_y;

    assign prod_x = item.col * wm1;
    assign prod_y = item.row * hm1;

    always_comb
    begin
        div_in[0].it = item;
        div_in[0].nx = {prod_x, 8'h00};
        div_in[0].ny = {prod_y, 8'h00};
        div_in[0].rx = div_in[0].nx[DW-1:QW];
        div_in[0].ry = div_in[0].ny[DW-1:QW];
        div_in[0].qx = '0;
        div_in[0].qy = '0;
        div_in_v[0]  = item_valid;
        for (int k = 1; k < QW; k++)
        begin
            div_in[k]   = div_reg[k-1];
            div_in_v[k] = dv_reg[k-1];
        end
    end

    // One restoring quotient bit per stage, both axes side by side.
    always_comb
    begin
        for (int k = 0; k < QW; k++)
        begin
            logic [8:0] sx;
            logic [8:0] sy;
            sx = div_step(div_in[k].rx, div_in[k].nx[QW-1-k], div_in[k].it.last);
            sy = div_step(div_in[k].ry, div_in[k].ny[QW-1-k], div_in[k].it.last);
            div_next[k]    = div_in[k];
            div_next[k].rx = sx[7:0];
            div_next[k].ry = sy[7:0];
            div_next[k].qx = {div_in[k].qx[QW-2:0], sx[8]};
            div_next[k].qy = {div_in[k].qy[QW-2:0], sy[8]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < QW; k++)
                dv_reg[k] <= 1'b0;
        end
        else
        begin
            for (int k = 0; k < QW; k++)
                if (rdy_div[k])
                    dv_reg[k] <= div_in_v[k];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < QW; k++)
            if (rdy_div[k])
                div_reg[k] <= div_next[k];
    end

    // Stage A: split source coordinates and find edge neighbours.
    addr_t a_reg;
    addr_t a_next;
    div_t  dl;

    assign dl = div_reg[QW-1];

    always_comb
    begin
        a_next.op  = dl.it.op;
        a_next.wr  = dl.it.wr;
        a_next.col = dl.it.col;
        a_next.row = dl.it.row;
        a_next.pix = dl.it.pix;
        // A target of one pixel maps everything to the origin.
        if (dl.it.last == 8'd0)
        begin
            a_next.ix = '0;
            a_next.iy = '0;
            a_next.fx = 8'd0;
            a_next.fy = 8'd0;
        end
        else
        begin
            a_next.ix = dl.qx[QW-1:8];
            a_next.iy = dl.qy[QW-1:8];
            a_next.fx = dl.qx[7:0];
            a_next.fy = dl.qy[7:0];
        end
        a_next.has_r = (32'(a_next.ix) + 32'd1) < 32'(w_eff);
        a_next.has_d = (32'(a_next.iy) + 32'd1) < 32'(h_eff);
    end

    // Stage B: four banks by row and column parity, one neighbour from each.
    fetch_t        b_reg;
    logic [23:0]   rdata_reg [4];
    logic [CW-1:0] cx1;
    logic [CW-1:0] ry1;
    logic [BA-1:0] waddr;
    logic [1:0]    wbank;

    assign cx1   = a_reg.has_r ? CW'(a_reg.ix + CW'(1)) : a_reg.ix;
    assign ry1   = a_reg.has_d ? CW'(a_reg.iy + CW'(1)) : a_reg.iy;
    assign waddr = bank_addr(a_reg.col[CW-1:0], a_reg.row[CW-1:0]);
    assign wbank = {a_reg.row[0], a_reg.col[0]};

    for (genvar g = 0; g < 4; g++)
    begin : g_bank
        logic [23:0]   mem [BD];
        logic [CW-1:0] rc;
        logic [CW-1:0] rr;
        logic          we;

        assign rc = (a_reg.ix[0] == g[0]) ? a_reg.ix : cx1;
        assign rr = (a_reg.iy[0] == g[1]) ? a_reg.iy : ry1;
        assign we = rdy_b && a_v_reg && a_reg.wr && (wbank == 2'(g));

        always_ff @(posedge clk)
        begin
            if (we)
                mem[waddr] <= a_reg.pix;
            if (rdy_b)
                rdata_reg[g] <= mem[bank_addr(rc, rr)];
        end
    end

    // Stage C: pick neighbours and form the bilinear weights.
    weight_t     c_reg;
    weight_t     c_next;
    logic [8:0]  ifx;
    logic [8:0]  ify;
    logic [8:0]  fx9;
    logic [8:0]  fy9;

    assign fx9 = {1'b0, b_reg.fx};
    assign fy9 = {1'b0, b_reg.fy};
    assign ifx = 9'd256 - fx9;
    assign ify = 9'd256 - fy9;

    always_comb
    begin
        c_next.col = b_reg.col;
        c_next.row = b_reg.row;
        c_next.pa  = rdata_reg[{b_reg.iy0, b_reg.ix0}];
        c_next.pb  = b_reg.has_r ? rdata_reg[{b_reg.iy0, ~b_reg.ix0}] : c_next.pa;
        c_next.pc  = b_reg.has_d ? rdata_reg[{~b_reg.iy0, b_reg.ix0}] : c_next.pa;
        c_next.pd  = (b_reg.has_r && b_reg.has_d) ?
                     rdata_reg[{~b_reg.iy0, ~b_reg.ix0}] : c_next.pa;
        c_next.wa  = 17'(ifx * ify);
        c_next.wb  = 17'(fx9 * ify);
        c_next.wc  = 17'(ifx * fy9);
        c_next.wd  = 17'(fx9 * fy9);
    end

    // Stage D: weighted channel products.
    prod_t d_reg;
    prod_t d_next;

    always_comb
    begin
        d_next.col = c_reg.col;
        d_next.row = c_reg.row;
        for (int k = 0; k < 3; k++)
        begin
            d_next.pr_a[k] = c_reg.pa[23-8*k -: 8] * c_reg.wa;
            d_next.pr_b[k] = c_reg.pb[23-8*k -: 8] * c_reg.wb;
            d_next.pr_c[k] = c_reg.pc[23-8*k -: 8] * c_reg.wc;
            d_next.pr_d[k] = c_reg.pd[23-8*k -: 8] * c_reg.wd;
        end
    end

    // Stage E: sum per channel and truncate to eight bits.
    blend_t e_reg;
    blend_t e_next;

    always_comb
    begin
        e_next.col = d_reg.col;
        e_next.row = d_reg.row;
        for (int k = 0; k < 3; k++)
        begin
            logic [26:0] s;
            s = 27'(d_reg.pr_a[k]) + 27'(d_reg.pr_b[k]) +
                27'(d_reg.pr_c[k]) + 27'(d_reg.pr_d[k]);
            e_next.ch[23-8*k -: 8] = s[23:16];
        end
    end

    // Output stage: optional night tint.
    blend_t      o_reg;
    blend_t      o_next;
    logic [14:0] tint_r;
    logic [14:0] tint_g;

    assign tint_r = e_reg.ch[23:16] * NIGHT_RED_Q8;
    assign tint_g = e_reg.ch[15:8] * NIGHT_GREEN_Q8;

    always_comb
    begin
        o_next = e_reg;
        if (cfg_q.night_mode)
        begin
            o_next.ch[23:16] = {1'b0, tint_r[14:8]};
            o_next.ch[15:8]  = {1'b0, tint_g[14:8]};
            o_next.ch[7:0]   = {1'b0, e_reg.ch[7:1]} + NIGHT_BLUE_OFFSET;
        end
    end

    // Stage valids; loads leave the pipeline once their write is done.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a)
                a_v_reg <= dv_reg[QW-1];
            if (rdy_b)
                b_v_reg <= a_v_reg && (a_reg.op == OP_READ);
            if (rdy_c)
                c_v_reg <= b_v_reg;
            if (rdy_d)
                d_v_reg <= c_v_reg;
            if (rdy_e)
                e_v_reg <= d_v_reg;
            if (rdy_o)
                o_v_reg <= e_v_reg;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (rdy_a)
            a_reg <= a_next;
        if (rdy_b)
        begin
            b_reg.col   <= a_reg.col;
            b_reg.row   <= a_reg.row;
            b_reg.fx    <= a_reg.fx;
            b_reg.fy    <= a_reg.fy;
            b_reg.has_r <= a_reg.has_r;
            b_reg.has_d <= a_reg.has_d;
            b_reg.ix0   <= a_reg.ix[0];
            b_reg.iy0   <= a_reg.iy[0];
        end
        if (rdy_c)
            c_reg <= c_next;
        if (rdy_d)
            d_reg <= d_next;
        if (rdy_e)
            e_reg <= e_next;
        if (rdy_o)
            o_reg <= o_next;
    end

    assign pix_out.valid     = o_v_reg;
    assign pix_out.out_col   = o_reg.col;
    assign pix_out.out_row   = o_reg.row;
    assign pix_out.out_red   = o_reg.ch[23:16];
    assign pix_out.out_green = o_reg.ch[15:8];
    assign pix_out.out_blue  = o_reg.ch[7:0];

endmodule

// ===== design/bilinear_rgb_scaler_night_tint.sv =====
// Bilinear RGB888 scaler with optional night tint.
// The pix_in channel carries load and read items. A load writes one source
// pixel at (col, row); loads outside the source size are dropped. A read
// names a pixel of the square target image and yields one transfer on
// pix_out with the clamped position and the blended color.
// The cfg channel writes src_width, src_height, target_size and night_mode
// by index 0 to 3 and is always ready; the user must see that it is written
// only while idle, as the block does not enforce this. Throughput is one
// item per cycle while pix_out is ready. The pixel store is split into four
// banks by row and column parity, so the four neighbours come out in one
// access. A read passes the input queue, one pipelined divider stage per
// quotient bit, then address, fetch, weight, product, sum and tint stages.
// When pix_out stalls, results hold and the pipeline and the two-entry
// input queue fill up before pix_in drops ready.
// Reset empties the pipeline and restores the default registers; the store
// content stays undefined until loaded.
module bilinear_rgb_scaler_night_tint #(
    parameter int MAX_SIDE = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    brs_cfg_if.sink    cfg,
    brs_pix_if.sink    pix_in,
    brs_res_if.source  pix_out
);
    import brs_pkg::*;

    cfg_t  cfg_q;
    item_t front_item;
    logic  front_valid;
    logic  front_ready;
    item_t back_item;
    logic  back_valid;
    logic  back_ready;

    brs_front #(.MAX_SIDE(MAX_SIDE)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .pix_in     (pix_in),
        .cfg_q      (cfg_q),
        .item       (front_item),
        .item_valid (front_valid),
        .item_ready (front_ready)
    );

    brs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_item  (back_item)
    );

    brs_back #(.MAX_SIDE(MAX_SIDE)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_q      (cfg_q),
        .item_valid (back_valid),
        .item_ready (back_ready),
        .item       (back_item),
        .pix_out    (pix_out)
    );

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    import brs_pkg::*;

    localparam int SIDE       = 64;
    localparam int LATENCY    = 40;
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;

    brs_cfg_if cfg_ch();
    brs_pix_if pix_ch();
    brs_res_if res_ch();

    bilinear_rgb_scaler_night_tint #(.MAX_SIDE(SIDE)) u_top
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch.sink),
        .pix_in  (pix_ch.sink),
        .pix_out (res_ch.source)
    );

    typedef struct packed
    {
        logic [7:0] col;
        logic [7:0] row;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_res_t;

    // One row of the directed stimulus table.
    typedef struct
    {
        op_t        op;
        logic [7:0] col;
        logic [7:0] row;
        logic [23:0] rgb;
        logic       known;
        pixel_res_t want;
    } stim_row_t;

    // Predictor state.
    logic [23:0] model_store [SIDE*SIDE];
    logic [6:0]  m_width;
    logic [6:0]  m_height;
    logic [7:0]  m_target;
    logic        m_night;

    pixel_res_t expected_pixels[$];
    int         failures;
    int         cycles;
    logic       rx_idle_off;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Cycle counter and timeout.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int clamp_side(logic [6:0] v);
        if (v < 1) return 1;
        if (v > SIDE) return SIDE;
        return v;
    endfunction

    function automatic logic [7:0] blend_chan(int a, int b, int c, int d,
                                              int wa, int wb, int wc, int wd);
        return 8'((a*wa + b*wb + c*wc + d*wd) >> 16);
    endfunction

    // Compute the scaled pixel for a read at (tc, tr).
    function automatic pixel_res_t scale_pixel(logic [7:0] tc, logic [7:0] tr);
        int w, h, tsz, c, r, gx, gy, ix, iy, fx, fy;
        int wa, wb, wc, wd, red, green, blue;
        logic [23:0] pa, pb, pc, pd;
        bit has_r, has_d;
        pixel_res_t res;
        w = clamp_side(m_width);
        h = clamp_side(m_height);
        tsz = (m_target < 1) ? 1 : m_target;
        c = (tc > tsz - 1) ? tsz - 1 : tc;
        r = (tr > tsz - 1) ? tsz - 1 : tr;
        gx = (tsz <= 1) ? 0 : (c * (w - 1) * 256) / (tsz - 1);
        gy = (tsz <= 1) ? 0 : (r * (h - 1) * 256) / (tsz - 1);
        ix = gx >> 8; fx = gx & 255;
        iy = gy >> 8; fy = gy & 255;
        has_r = (ix + 1) < w;
        has_d = (iy + 1) < h;
        pa = model_store[iy*SIDE + ix];
        pb = has_r ? model_store[iy*SIDE + ix + 1] : pa;
        pc = has_d ? model_store[(iy+1)*SIDE + ix] : pa;
        pd = (has_r && has_d) ? model_store[(iy+1)*SIDE + ix + 1] : pa;
        wa = (256 - fx) * (256 - fy);
        wb = fx * (256 - fy);
        wc = (256 - fx) * fy;
        wd = fx * fy;
        red   = blend_chan(pa[23:16], pb[23:16], pc[23:16], pd[23:16], wa, wb, wc, wd);
        green = blend_chan(pa[15:8], pb[15:8], pc[15:8], pd[15:8], wa, wb, wc, wd);
        blue  = blend_chan(pa[7:0], pb[7:0], pc[7:0], pd[7:0], wa, wb, wc, wd);
        if (m_night)
        begin
            red   = (red * NIGHT_RED_Q8) >> 8;
            green = (green * NIGHT_GREEN_Q8) >> 8;
            blue  = ((blue * 128) >> 8) + NIGHT_BLUE_OFFSET;
        end
        res.col = 8'(c);
        res.row = 8'(r);
        res.red = 8'(red);
        res.green = 8'(green);
        res.blue = 8'(blue);
        return res;
    endfunction

    // Apply an accepted item to the predictor.
    function automatic void predict_item(op_t op, logic [7:0] c, logic [7:0] r,
                                         logic [23:0] rgb);
        if (op == OP_LOAD)
        begin
            if (c < clamp_side(m_width) && r < clamp_side(m_height))
                model_store[r*SIDE + c] = rgb;
        end
        else
        begin
            expected_pixels.push_back(scale_pixel(c, r));
        end
    endfunction

    // Result checker and receiver stalls.
    always @(posedge clk)
    begin
        pixel_res_t got;
        pixel_res_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got = '{res_ch.out_col, res_ch.out_row, res_ch.out_red,
                    res_ch.out_green, res_ch.out_blue};
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                failures++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (got !== want)
                begin
                    $display("%0t: mismatch expected %h actual %h", $time, want, got);
                    failures++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        res_ch.ready <= rx_idle_off ? 1'b1 : ($urandom_range(99) >= 13);
    end

    // Drive one register write; the caller drops valid after its last write.
    task automatic write_reg(reg_idx_t idx, logic [7:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        case (idx)
            REG_SRC_WIDTH:   m_width  = value[6:0];
            REG_SRC_HEIGHT:  m_height = value[6:0];
            REG_TARGET_SIZE: m_target = value;
            REG_NIGHT_MODE:  m_night  = value[0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Drive one item; valid stays high across back-to-back transfers.
    task automatic send_item(op_t op, logic [7:0] c, logic [7:0] r, logic [23:0] rgb,
                             bit may_idle);
        if (may_idle)
        begin
            while ($urandom_range(99) < 13)
            begin
                pix_ch.valid <= 1'b0;
                @(negedge clk);
            end
        end
        pix_ch.valid     <= 1'b1;
        pix_ch.operation <= op;
        pix_ch.col       <= c;
        pix_ch.row       <= r;
        pix_ch.in_red    <= rgb[23:16];
        pix_ch.in_green  <= rgb[15:8];
        pix_ch.in_blue   <= rgb[7:0];
        @(posedge clk);
        while (!pix_ch.ready) @(posedge clk);
        predict_item(op, c, r, rgb);
        @(negedge clk);
    endtask

    task automatic drain();
        pix_ch.valid <= 1'b0;
        while (expected_pixels.size() != 0) @(negedge clk);
        repeat (LATENCY) @(negedge clk);
    endtask

    // Fill the whole active source area with random pixels.
    task automatic fill_source();
        int w, h;
        w = clamp_side(m_width);
        h = clamp_side(m_height);
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
                send_item(OP_LOAD, 8'(c), 8'(r), 24'($urandom), 1'b1);
    endtask

    // Random mix of in-range and clamped reads, loads inside the source and ignored loads.
    task automatic random_burst(int count);
        int w, h, t, sel;
        w = clamp_side(m_width);
        h = clamp_side(m_height);
        t = (m_target < 1) ? 1 : m_target;
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(99);
            if (sel < 60)
                send_item(OP_READ, 8'($urandom_range(t - 1)),
                          8'($urandom_range(t - 1)), 24'($urandom), !rx_idle_off);
            else if (sel < 70)
                send_item(OP_READ, 8'($urandom_range(254)),
                          8'($urandom_range(254)), 24'($urandom), !rx_idle_off);
            else if (sel < 92)
                send_item(OP_LOAD, 8'($urandom_range(w - 1)),
                          8'($urandom_range(h - 1)), 24'($urandom), !rx_idle_off);
            else
                send_item(OP_LOAD, 8'($urandom_range(255)),
                          8'($urandom_range(255)), 24'($urandom), !rx_idle_off);
        end
    endtask

    task automatic set_config(int w, int h, int t, int n);
        drain();
        write_reg(REG_SRC_WIDTH, 8'(w));
        write_reg(REG_SRC_HEIGHT, 8'(h));
        write_reg(REG_TARGET_SIZE, 8'(t));
        write_reg(REG_NIGHT_MODE, 8'(n));
        cfg_ch.valid <= 1'b0;
    endtask

    stim_row_t directed [] = '{
        '{OP_LOAD, 8'd0, 8'd0, 24'hFFFFFF, 1'b0, '0},
        '{OP_LOAD, 8'd1, 8'd0, 24'h000000, 1'b0, '0},
        '{OP_LOAD, 8'd0, 8'd1, 24'h00FF00, 1'b0, '0},
        '{OP_LOAD, 8'd1, 8'd1, 24'h0000FF, 1'b0, '0},
        '{OP_LOAD, 8'd2, 8'd0, 24'h123456, 1'b0, '0},
        '{OP_LOAD, 8'd255, 8'd255, 24'hABCDEF, 1'b0, '0},
        '{OP_READ, 8'd0, 8'd0, 24'h0, 1'b1, '{8'd0, 8'd0, 8'hFF, 8'hFF, 8'hFF}},
        '{OP_READ, 8'd1, 8'd0, 24'hFFFFFF, 1'b0, '0},
        '{OP_READ, 8'd0, 8'd1, 24'h0, 1'b0, '0},
        '{OP_READ, 8'd1, 8'd1, 24'h0, 1'b0, '0},
        '{OP_READ, 8'd2, 8'd2, 24'h0, 1'b0, '0},
        '{OP_READ, 8'd254, 8'd254, 24'h0, 1'b0, '0},
        '{OP_READ, 8'd255, 8'd0, 24'h0, 1'b0, '0}
    };

    initial
    begin
        failures = 0;
        cycles = 0;
        rx_idle_off = 1'b0;
        rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_SRC_WIDTH;
        cfg_ch.data = '0;
        pix_ch.valid = 1'b0;
        pix_ch.operation = OP_LOAD;
        pix_ch.col = '0;
        pix_ch.row = '0;
        pix_ch.in_red = '0;
        pix_ch.in_green = '0;
        pix_ch.in_blue = '0;
        res_ch.ready = 1'b0;
        m_width = SRC_WIDTH_RESET;
        m_height = SRC_HEIGHT_RESET;
        m_target = TARGET_SIZE_RESET;
        m_night = 1'b0;
        foreach (model_store[i]) model_store[i] = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: the 32x32 default source would read unwritten
        // pixels, so shrink to 2x2 source with target 3 first.
        write_reg(REG_SRC_WIDTH, 8'd2);
        write_reg(REG_SRC_HEIGHT, 8'd2);
        write_reg(REG_TARGET_SIZE, 8'd3);
        cfg_ch.valid <= 1'b0;
        foreach (directed[i])
        begin
            send_item(directed[i].op, directed[i].col, directed[i].row,
                      directed[i].rgb, 1'b0);
            if (directed[i].known)
                expected_pixels[expected_pixels.size()-1] = directed[i].want;
        end
        // Night mode on a white pixel and the single-pixel target.
        set_config(2, 2, 1, 1);
        send_item(OP_READ, 8'd0, 8'd0, 24'h0, 1'b0);
        expected_pixels[expected_pixels.size()-1] = '{8'd0, 8'd0, 8'd76, 8'd89, 8'd191};
        send_item(OP_READ, 8'd200, 8'd17, 24'h0, 1'b0);
        set_config(0, 0, 0, 0);
        send_item(OP_LOAD, 8'd0, 8'd0, 24'h000000, 1'b0);
        send_item(OP_READ, 8'd9, 8'd9, 24'h0, 1'b0);
        expected_pixels[expected_pixels.size()-1] = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0};

        // Random phases over several settings, extremes included.
        set_config(8, 5, 12, 0);
        fill_source();
        random_burst(300);
        // Sender holds off until every result is back.
        drain();
        random_burst(100);
        set_config(64, 4, 255, 1);
        fill_source();
        rx_idle_off = 1'b1;
        random_burst(250);
        rx_idle_off = 1'b0;
        set_config(1, 7, 2, 0);
        fill_source();
        random_burst(150);
        set_config(127, 2, 200, 1);
        fill_source();
        random_burst(150);
        set_config(3, 64, 9, 0);
        fill_source();
        random_burst(100);
        set_config(6, 4, 128, 1);
        fill_source();
        random_burst(150);
        drain();

        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
